>>> rtl/kvt_pkg.sv
// Shared constants and types for the key/value table unit.
// Holds the default table geometry, the item field widths, request
// codes and status codes. Depends on nothing.
package kvt_pkg;

    // Default table geometry.
    localparam int KVT_DEPTH      = 16;
    localparam int KVT_KEY_BITS   = 64;
    localparam int KVT_VALUE_BITS = 64;

    // Fixed widths of the item fields on the ports.
    localparam int TYPE_FIELD_W   = 2;
    localparam int KEY_FIELD_W    = 64;
    localparam int VALUE_FIELD_W  = 64;
    localparam int STATUS_FIELD_W = 2;

    typedef logic [TYPE_FIELD_W-1:0]   kvt_op_t;
    typedef logic [STATUS_FIELD_W-1:0] kvt_status_t;

    // Request codes.
    localparam kvt_op_t OP_GET = 2'd0;
    localparam kvt_op_t OP_PUT = 2'd1;
    localparam kvt_op_t OP_DEL = 2'd2;

    // Result status codes.
    localparam kvt_status_t ST_OK        = 2'd0;
    localparam kvt_status_t ST_NOT_FOUND = 2'd1;
    localparam kvt_status_t ST_FULL      = 2'd2;

endpackage

>>> rtl/kvt_entry_mem.sv
// Entry store of the key/value table: a simple dual-port memory with one
// write port and one read port whose data is registered. Depends on nothing.
module kvt_entry_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/key_value_table_unit.sv
// Key/value table unit: get, put and delete on a packed table of up to TABLE_DEPTH entries.
// Each item scans the live entries for its key, resolves, and then offers its result.
// A delete that hits first shifts every later entry one place lower, then offers its result.
// One item is in work at a time; the result register lets the next item in while a result waits.
// rst_n clears the table to empty at once; memory contents are not cleared and need no sweep.
// Depends on kvt_pkg and kvt_entry_mem.
module key_value_table_unit
    import kvt_pkg::*;
#(
    parameter int TABLE_DEPTH = KVT_DEPTH,
    parameter int KEY_BITS    = KVT_KEY_BITS,
    parameter int VALUE_BITS  = KVT_VALUE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Request items.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: req_key [63:0], req_value [127:64].
    input  logic [KEY_FIELD_W+VALUE_FIELD_W-1:0] s_axis_tdata,
    // Fields from bit 0: req_type [1:0].
    input  logic [TYPE_FIELD_W-1:0]              s_axis_tuser,
    // Result items.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: read_value [63:0].
    output logic [VALUE_FIELD_W-1:0]             m_axis_tdata,
    // Fields from bit 0: status [1:0].
    output logic [STATUS_FIELD_W-1:0]            m_axis_tuser
);

    // Address width of the entry store, and count width that can also hold
    // the full depth.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = KEY_BITS + VALUE_BITS;

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_RESOLVE = 3'd2;
    localparam logic [2:0] S_SHIFT   = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    kvt_op_t               op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;

    // Scan pointer: scan_idx is the next address to read; cmp_idx tags the
    // word that arrives from the memory in this cycle.
    logic [CW-1:0]         scan_idx_reg, scan_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                  found_reg, found_next;
    logic [CW-1:0]         slot_reg, slot_next;
    logic [VALUE_BITS-1:0] hit_value_reg, hit_value_next;

    // Delete shift: reads run one address ahead of writes.
    logic [CW-1:0]         rd_idx_reg, rd_idx_next;
    logic [CW-1:0]         wr_idx_reg, wr_idx_next;
    logic                  pend_reg, pend_next;

    kvt_status_t           res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [VALUE_FIELD_W-1:0] m_tdata_reg, m_tdata_next;
    kvt_status_t              m_tuser_reg, m_tuser_next;

    // Entry store port signals.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic                  scan_issue;
    logic                  scan_hit;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic                  out_free;

    kvt_entry_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (EW)
    ) u_entry_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Each entry word holds the key in its low bits and the value above it.
    assign rd_key   = mem_rdata[KEY_BITS-1:0];
    assign rd_value = mem_rdata[EW-1:KEY_BITS];

    assign scan_issue = (scan_idx_reg < count_reg);
    assign scan_hit   = cmp_vld_reg && (rd_key == key_reg);
    assign out_free   = !m_tvalid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        hit_value_next  = hit_value_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        mem_we    = 1'b0;
        mem_waddr = wr_idx_reg[AW-1:0];
        mem_wdata = {val_reg, key_reg};
        mem_raddr = scan_idx_reg[AW-1:0];

        // The result register drains independently of the sequencer.
        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next       = s_axis_tuser;
                    key_next      = s_axis_tdata[KEY_BITS-1:0];
                    val_next      = s_axis_tdata[KEY_FIELD_W +: VALUE_BITS];
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    found_next    = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle and compare the word read in the
                // cycle before; live entries are always written.
                cmp_vld_next = scan_issue;
                cmp_idx_next = scan_idx_reg;
                if (scan_issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (scan_hit)
                begin
                    found_next     = 1'b1;
                    slot_next      = cmp_idx_reg;
                    hit_value_next = rd_value;
                    state_next     = S_RESOLVE;
                end
                else if (!scan_issue)
                begin
                    // Every live entry has been compared without a match.
                    found_next = 1'b0;
                    state_next = S_RESOLVE;
                end
            end

            S_RESOLVE:
            begin
                res_status_next = ST_OK;
                res_value_next  = '0;
                state_next      = S_DONE;
                unique case (op_reg)
                    OP_GET:
                    begin
                        if (found_reg)
                        begin
                            res_value_next = hit_value_reg;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_PUT:
                    begin
                        if (found_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = slot_reg[AW-1:0];
                        end
                        else if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            // Append the new entry at the end of the packed table.
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_DEL:
                    begin
                        if (found_reg)
                        begin
                            wr_idx_next = slot_reg;
                            rd_idx_next = slot_reg + CW'(1);
                            pend_next   = 1'b0;
                            state_next  = S_SHIFT;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // The unused request code changes nothing.
                        res_status_next = ST_OK;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // Entry rd_idx is read while the entry read in the cycle
                // before is written one place lower.
                if (pend_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = wr_idx_reg[AW-1:0];
                    mem_wdata   = mem_rdata;
                    wr_idx_next = wr_idx_reg + CW'(1);
                end
                if (rd_idx_reg < count_reg)
                begin
                    mem_raddr   = rd_idx_reg[AW-1:0];
                    rd_idx_next = rd_idx_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next                 = 1'b1;
                    m_tuser_next                  = res_status_reg;
                    m_tdata_next                  = '0;
                    m_tdata_next[VALUE_BITS-1:0]  = res_value_reg;
                    state_next                    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cmp_vld_reg  <= cmp_vld_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        hit_value_reg  <= hit_value_next;
        rd_idx_reg     <= rd_idx_next;
        wr_idx_reg     <= wr_idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // The table never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds the table depth");

    // The count moves by at most one entry per item.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + CW'(1)) ||
            (count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count changed by more than one");

    // The entry store is written only while resolving or shifting.
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_RESOLVE) || (state_reg == S_SHIFT))
        else $error("entry store written outside resolve or shift");

    // An accepted item always starts a scan.
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_SCAN))
        else $error("accepted item did not start a scan");

    // A new result appears only when the sequencer finishes an item.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the finishing state");

endmodule
